// ===== src/svm_pkg.sv =====
// Shared constants, command and status codes, and control/status bundles for the stack VM.
package svm_pkg;

  // Fixed geometry: addresses are 10 bits, counts and the stack pointer 11 bits
  localparam int STACK_DEPTH = 1024;
  localparam int PROG_DEPTH  = 1024;
  localparam int VALUE_WIDTH = 32;

  localparam int CMD_W     = 4;
  localparam int VAL_W     = 32;
  localparam int ADDR_W    = $clog2(PROG_DEPTH);
  localparam int MEM_AW    = $clog2(STACK_DEPTH);
  localparam int PTR_W     = MEM_AW + 1;
  localparam int CNT_W     = 11;
  localparam int DROP_W    = CNT_W + 1;
  localparam int CFG_IDX_W = 1;
  localparam int STS_W     = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ARGS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LOCALS = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_ARG    = 4'd0,
    CMD_START_FRAME = 4'd1,
    CMD_CONST       = 4'd2,
    CMD_GET_LOCAL   = 4'd3,
    CMD_SET_LOCAL   = 4'd4,
    CMD_ADD         = 4'd5,
    CMD_SUB         = 4'd6,
    CMD_JUMP        = 4'd7,
    CMD_JZ          = 4'd8,
    CMD_JNEG        = 4'd9,
    CMD_RETURN      = 4'd10,
    CMD_POP_RESULT  = 4'd11
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic cap;         // capture request, read first operand
    logic rd2;         // latch first operand, read second
    logic exec;        // write back, commit state, load result
    logic clear_step;  // write one zero local
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic start_clear;
    logic clear_last;
  } sts_t;

endpackage

// ===== src/svm_cmd_if.sv =====
// Command request channel: valid/ready handshake with command payload.
interface svm_cmd_if;
  import svm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [VAL_W-1:0]  value_in;
  logic [ADDR_W-1:0]        local_index;
  logic [ADDR_W-1:0]        jump_target;

  modport source (output valid, cmd, value_in, local_index, jump_target, input ready);
  modport sink   (input valid, cmd, value_in, local_index, jump_target, output ready);
endinterface

// ===== src/svm_res_if.sv =====
// Result request channel: valid/ready handshake with result payload.
interface svm_res_if;
  import svm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ADDR_W-1:0]        next_address;
  logic signed [VAL_W-1:0]  top_value;
  logic                     finished;
  logic [STS_W-1:0]         status;

  modport source (output valid, next_address, top_value, finished, status, input ready);
  modport sink   (input valid, next_address, top_value, finished, status, output ready);
endinterface

// ===== src/svm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module svm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, hold data when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/svm_ctrl.sv =====
// Sequencer for the stack VM: accepts requests, steps reads, clears and commit.
module svm_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [svm_pkg::CMD_W-1:0] in_cmd,
  output logic                    out_valid,
  input  logic                    out_ready,
  input  svm_pkg::sts_t           sts,
  output svm_pkg::ctl_t           ctl
);
  import svm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ2 = 4'b0010,
    S_EXEC  = 4'b0100,
    S_CLEAR = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   out_free;
  cmd_t   in_cmd_dec;

  assign in_cmd_dec = cmd_t'(in_cmd);
  assign out_free   = !out_valid || out_ready;
  assign in_ready   = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.cap = 1'b1;
          if (in_cmd_dec == CMD_ADD || in_cmd_dec == CMD_SUB) begin
            state_next = S_READ2;
          end else begin
            state_next = S_EXEC;
          end
        end
      end
      S_READ2: begin
        ctl.rd2    = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (sts.start_clear) begin
          state_next = S_CLEAR;
        end else if (out_free) begin
          ctl.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CLEAR: begin
        ctl.clear_step = 1'b1;
        if (sts.clear_last && out_free) begin
          ctl.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold result valid until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_exec_free: assert property (@(posedge clk) disable iff (rst)
    ctl.exec |-> (!out_valid || out_ready))
    else $error("commit while result register is occupied");

  a_exec_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.exec |=> (state == S_IDLE))
    else $error("no return to idle after commit");

  a_cap_busy: assert property (@(posedge clk) disable iff (rst)
    ctl.cap |=> !in_ready)
    else $error("new request taken before the previous one finished");

endmodule

// ===== src/svm_datapath.sv =====
// Stack VM datapath: machine registers, stack memory, address and ALU logic.
module svm_datapath #(
  parameter int VALUE_WIDTH = svm_pkg::VALUE_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  svm_pkg::ctl_t                   ctl,
  output svm_pkg::sts_t                   sts,
  input  logic [svm_pkg::CMD_W-1:0]       in_cmd,
  input  logic signed [svm_pkg::VAL_W-1:0] in_value,
  input  logic [svm_pkg::ADDR_W-1:0]      in_local_index,
  input  logic [svm_pkg::ADDR_W-1:0]      in_jump_target,
  input  logic                            cfg_we,
  input  logic [svm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [svm_pkg::CNT_W-1:0]       cfg_data,
  output logic [svm_pkg::ADDR_W-1:0]      next_address,
  output logic signed [svm_pkg::VAL_W-1:0] top_value,
  output logic                            finished,
  output logic [svm_pkg::STS_W-1:0]       status
);
  import svm_pkg::*;

  // Machine state
  logic [PTR_W-1:0]  top, top_next, fb, fb_next;
  logic [ADDR_W-1:0] ip, ip_next;
  logic [CNT_W-1:0]  frame_args, frame_locals;

  // Captured request and operands
  cmd_t                   cmd_q;
  logic [VALUE_WIDTH-1:0] val_q, b_q;
  logic [ADDR_W-1:0]      idx_q, tgt_q;
  logic [MEM_AW-1:0]      cnt;

  // Memory and decode
  logic                   re, we;
  logic [MEM_AW-1:0]      raddr, waddr;
  logic [VALUE_WIDTH-1:0] rdata, wdata, res_val;
  logic                   fin;
  status_t                err;
  logic [DROP_W-1:0]      drop;
  logic [PTR_W-1:0]       top_inc1, top_dec1, top_dec2, ret_top, ret_dec1;
  logic [MEM_AW-1:0]      slot_base, slot_in, slot_q;
  logic [ADDR_W-1:0]      ip_inc, tgt_inc;

  assign drop     = DROP_W'(frame_args) + DROP_W'(frame_locals);
  assign top_inc1 = top + PTR_W'(1);
  assign top_dec1 = top - PTR_W'(1);
  assign top_dec2 = top - PTR_W'(2);
  assign ret_top  = PTR_W'(DROP_W'(top) - drop);
  assign ret_dec1 = ret_top - PTR_W'(1);
  assign ip_inc   = ip + ADDR_W'(1);
  assign tgt_inc  = tgt_q + ADDR_W'(1);

  // Frame-relative slot address, wraps at the stack depth
  assign slot_base = fb[MEM_AW-1:0] - frame_args[MEM_AW-1:0] - frame_locals[MEM_AW-1:0];
  assign slot_in   = slot_base + MEM_AW'(in_local_index);
  assign slot_q    = slot_base + MEM_AW'(idx_q);

  // Overflow, underflow and bad-command checks
  always_comb begin
    err = ST_OK;
    unique case (cmd_q)
      CMD_PUSH_ARG, CMD_CONST, CMD_GET_LOCAL: begin
        if (top[PTR_W-1]) err = ST_OVER;
      end
      CMD_START_FRAME: begin
        if (DROP_W'(top) + DROP_W'(frame_locals) > DROP_W'(STACK_DEPTH)) err = ST_OVER;
      end
      CMD_SET_LOCAL, CMD_JZ, CMD_JNEG, CMD_POP_RESULT: begin
        if (top == '0) err = ST_UNDER;
      end
      CMD_ADD, CMD_SUB: begin
        if (top < PTR_W'(2)) err = ST_UNDER;
      end
      CMD_RETURN: begin
        if (DROP_W'(top) < drop + DROP_W'(1)) err = ST_UNDER;
      end
      CMD_JUMP: begin
        err = ST_OK;
      end
      default: begin
        err = ST_BAD;
      end
    endcase
  end

  assign sts.start_clear = (cmd_q == CMD_START_FRAME) && (err == ST_OK) && (frame_locals != '0);
  assign sts.clear_last  = (CNT_W'(cnt) == frame_locals - CNT_W'(1));

  // Read port: first operand on capture, second on rd2
  assign re = ctl.cap || ctl.rd2;
  always_comb begin
    if (ctl.rd2) begin
      raddr = top_dec2[MEM_AW-1:0];
    end else if (cmd_t'(in_cmd) == CMD_GET_LOCAL) begin
      raddr = slot_in;
    end else begin
      raddr = top_dec1[MEM_AW-1:0];
    end
  end

  // Write port: zero locals or write-back of the command
  always_comb begin
    we    = 1'b0;
    waddr = top[MEM_AW-1:0];
    wdata = val_q;
    if (ctl.clear_step) begin
      we    = 1'b1;
      waddr = top[MEM_AW-1:0] + cnt;
      wdata = '0;
    end else if (ctl.exec && err == ST_OK) begin
      case (cmd_q)
        CMD_PUSH_ARG, CMD_CONST: begin
          we = 1'b1;
        end
        CMD_GET_LOCAL: begin
          we    = 1'b1;
          wdata = rdata;
        end
        CMD_SET_LOCAL: begin
          we    = 1'b1;
          waddr = slot_q;
          wdata = rdata;
        end
        CMD_ADD: begin
          we    = 1'b1;
          waddr = top_dec2[MEM_AW-1:0];
          wdata = rdata + b_q;
        end
        CMD_SUB: begin
          we    = 1'b1;
          waddr = top_dec2[MEM_AW-1:0];
          wdata = rdata - b_q;
        end
        CMD_RETURN: begin
          we    = 1'b1;
          waddr = ret_dec1[MEM_AW-1:0];
          wdata = rdata;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  // Next machine state; errors leave everything as it was
  always_comb begin
    top_next = top;
    fb_next  = fb;
    ip_next  = ip;
    res_val  = '0;
    fin      = 1'b0;
    if (err == ST_OK) begin
      case (cmd_q)
        CMD_PUSH_ARG: begin
          top_next = top_inc1;
        end
        CMD_CONST, CMD_GET_LOCAL: begin
          top_next = top_inc1;
          ip_next  = ip_inc;
        end
        CMD_START_FRAME: begin
          top_next = top + PTR_W'(frame_locals);
          fb_next  = top + PTR_W'(frame_locals);
          ip_next  = '0;
        end
        CMD_SET_LOCAL, CMD_ADD, CMD_SUB: begin
          top_next = top_dec1;
          ip_next  = ip_inc;
        end
        CMD_JUMP: begin
          ip_next = tgt_inc;
        end
        CMD_JZ: begin
          top_next = top_dec1;
          ip_next  = (rdata == '0) ? tgt_inc : ip_inc;
        end
        CMD_JNEG: begin
          top_next = top_dec1;
          ip_next  = rdata[VALUE_WIDTH-1] ? tgt_inc : ip_inc;
        end
        CMD_RETURN: begin
          top_next = ret_top;
          res_val  = rdata;
          fin      = 1'b1;
        end
        CMD_POP_RESULT: begin
          top_next = top_dec1;
          res_val  = rdata;
        end
        default: begin
          top_next = top;
        end
      endcase
    end
  end

  // Machine registers and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      top          <= '0;
      fb           <= '0;
      ip           <= '0;
      frame_args   <= '0;
      frame_locals <= '0;
    end else begin
      if (ctl.exec) begin
        top <= top_next;
        fb  <= fb_next;
        ip  <= ip_next;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FRAME_ARGS:   frame_args   <= cfg_data;
          CFG_FRAME_LOCALS: frame_locals <= cfg_data;
          default:          frame_args   <= frame_args;
        endcase
      end
    end
  end

  // Capture request, latch operand, step clear counter
  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      cmd_q <= cmd_t'(in_cmd);
      val_q <= VALUE_WIDTH'(in_value);
      idx_q <= in_local_index;
      tgt_q <= in_jump_target;
      cnt   <= '0;
    end else if (ctl.clear_step && !sts.clear_last) begin
      cnt <= cnt + MEM_AW'(1);
    end
    if (ctl.rd2) begin
      b_q <= rdata;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      next_address <= ip_next;
      top_value    <= VAL_W'(res_val);
      finished     <= fin;
      status       <= err;
    end
  end

  svm_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  a_top_range: assert property (@(posedge clk) disable iff (rst)
    top <= PTR_W'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_clear_fit: assert property (@(posedge clk) disable iff (rst)
    ctl.clear_step |-> (DROP_W'(top) + DROP_W'(cnt) < DROP_W'(STACK_DEPTH)))
    else $error("local clear outside the stack");

  a_exec_no_clear_err: assert property (@(posedge clk) disable iff (rst)
    ctl.clear_step |-> (cmd_q == CMD_START_FRAME && err == ST_OK))
    else $error("local clear for a command that does not open a frame");

endmodule

// ===== src/stack_vm_execute.sv =====
// Top level of the stack VM execute stage: controller, datapath and channels.
//
//  channel    dir  payload                                            handshake
//  cmd_chan   in   cmd, value_in, local_index, jump_target            valid/ready
//  res_chan   out  next_address, top_value, finished, status          valid/ready
//  cfg_*      in   cfg_index (0 frame_args, 1 frame_locals), cfg_data cfg_we
//
// A request is accepted, then does a read-modify-write of the stack RAM;
// add and sub read twice, as the single RAM read port fetches two operands.
// Start frame with L locals clears L locals, one zero written per cycle.
// The result waits in an output register; the next request is accepted
// meanwhile, and its commit stalls until the pending result is taken.
// Synchronous active-high reset clears the pointers, the instruction address
// and the frame registers; the stack RAM is not cleared.
module stack_vm_execute #(
  parameter int VALUE_WIDTH = svm_pkg::VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  svm_cmd_if.sink                       cmd_chan,
  svm_res_if.source                     res_chan,
  input  logic                          cfg_we,
  input  logic [svm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [svm_pkg::CNT_W-1:0]     cfg_data
);
  import svm_pkg::*;

  ctl_t ctl;
  sts_t sts;

  svm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd_chan.valid),
    .in_ready  (cmd_chan.ready),
    .in_cmd    (cmd_chan.cmd),
    .out_valid (res_chan.valid),
    .out_ready (res_chan.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  svm_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .sts            (sts),
    .in_cmd         (cmd_chan.cmd),
    .in_value       (cmd_chan.value_in),
    .in_local_index (cmd_chan.local_index),
    .in_jump_target (cmd_chan.jump_target),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .next_address   (res_chan.next_address),
    .top_value      (res_chan.top_value),
    .finished       (res_chan.finished),
    .status         (res_chan.status)
  );

endmodule
